/* hw/rtl/sdspi_pkg.sv */
// Shared types, constants and the CRC7 byte update for the SD SPI command exchange.
`default_nettype none

package sdspi_pkg;

  // Command codes carried by an input item
  localparam logic CMD_ISSUE   = 1'b0;
  localparam logic CMD_RECEIVE = 1'b1;

  // Frame layout and fixed bytes
  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned IDX_W       = 3;
  localparam logic [IDX_W-1:0] IDX_START = 3'd0;
  localparam logic [IDX_W-1:0] IDX_ARG3  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_ARG2  = 3'd2;
  localparam logic [IDX_W-1:0] IDX_ARG1  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_ARG0  = 3'd4;
  localparam logic [IDX_W-1:0] IDX_CRC   = 3'd5;
  localparam logic [1:0] START_BITS = 2'b01;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;

  // CRC7, generator x^7 + x^3 + 1, kept as 7 bits
  localparam logic [6:0] CRC7_POLY = 7'h09;

  // Response try count
  localparam int unsigned TRIES_W            = 4;
  localparam int unsigned RESPONSE_TRIES_DEF = 9;

  typedef struct packed {
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       r1_valid;
    logic [7:0] r1;
    logic       no_response;
    logic       last;
  } rsp_t;

  // Shift one byte, MSB first, through the CRC7 register
  function automatic logic [6:0] crc7_update(input logic [6:0] crc_in,
                                             input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 7; b >= 0; b--) begin
      fb = c[6] ^ data[b];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sd_spi_command_exchange.sv */
// Top level of the SD SPI-mode command exchange: frame sender and R1 wait.
//
//   channel | direction | payload       | handshake
//   req     | in        | sdspi_pkg::req_t | req_valid / req_stall
//   rsp     | out       | sdspi_pkg::rsp_t | rsp_valid / rsp_stall
//
// An issue item is sent as 6 frame bytes: the frame sequencer emits one byte a cycle
// through the single result register while rsp_stall does not hold it, folding the
// command and argument bytes into the CRC7. A receive while idle gives no result.
// Reset clears the input holding stage, result valid, sequencer and wait state.
// rsp_stall holds the result register; a held item that emits then waits and req_stall rises.
`default_nettype none

module sd_spi_command_exchange #(
  parameter int unsigned RESPONSE_TRIES = sdspi_pkg::RESPONSE_TRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_stall,
  input  wire sdspi_pkg::req_t req,
  output      logic            rsp_valid,
  input  wire logic            rsp_stall,
  output      sdspi_pkg::rsp_t rsp
);

  import sdspi_pkg::*;

  localparam logic [TRIES_W-1:0] TRY_LIMIT = TRIES_W'(RESPONSE_TRIES);

  // Input holding stage
  logic             hold_valid;
  req_t             hold;

  // Frame sequencer and exchange state
  logic [IDX_W-1:0]   byte_idx;
  logic [6:0]         crc;
  logic               awaiting;
  logic [TRIES_W-1:0] tries;

  // Step control
  logic             is_issue;
  logic             emit;
  logic             out_free;
  logic             step;
  logic             consume;
  logic [7:0]       frame_byte;
  logic [6:0]       crc_next;
  logic [TRIES_W-1:0] tries_next;
  rsp_t             rsp_next;

  assign is_issue = (hold.command == CMD_ISSUE);
  assign emit     = hold_valid && (is_issue || awaiting);
  assign out_free = !rsp_valid || !rsp_stall;
  assign step     = hold_valid && (!emit || out_free);
  assign consume  = step && (!is_issue || byte_idx == IDX_CRC);
  assign req_stall = hold_valid && !consume;

  // Select the frame byte for the current sequencer position
  always_comb begin
    unique case (byte_idx)
      IDX_START: frame_byte = {START_BITS, hold.cmd_index};
      IDX_ARG3:  frame_byte = hold.argument[31:24];
      IDX_ARG2:  frame_byte = hold.argument[23:16];
      IDX_ARG1:  frame_byte = hold.argument[15:8];
      IDX_ARG0:  frame_byte = hold.argument[7:0];
      IDX_CRC:   frame_byte = {crc, 1'b1};
      default:   frame_byte = FILL_BYTE;
    endcase
  end

  // Fold the outgoing byte into the CRC, starting fresh on the command byte
  assign crc_next   = crc7_update((byte_idx == IDX_START) ? 7'd0 : crc, frame_byte);
  assign tries_next = tries + TRIES_W'(1);

  // Build the result for this step
  always_comb begin
    rsp_next = '0;
    if (is_issue) begin
      rsp_next.tx_valid = 1'b1;
      rsp_next.tx_byte  = frame_byte;
      rsp_next.last     = (byte_idx == IDX_CRC);
    end else if (!hold.rx_byte[7]) begin
      rsp_next.r1_valid = 1'b1;
      rsp_next.r1       = hold.rx_byte;
      rsp_next.last     = 1'b1;
    end else if (tries_next >= TRY_LIMIT) begin
      rsp_next.r1_valid    = 1'b1;
      rsp_next.r1          = hold.rx_byte;
      rsp_next.no_response = 1'b1;
      rsp_next.last        = 1'b1;
    end else begin
      rsp_next.tx_valid = 1'b1;
      rsp_next.tx_byte  = FILL_BYTE;
      rsp_next.last     = 1'b1;
    end
  end

  // Hold the accepted item until its last step
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
  end

  // Advance the frame sequencer and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= IDX_START;
    end else if (step && is_issue) begin
      byte_idx <= (byte_idx == IDX_CRC) ? IDX_START : byte_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_issue && byte_idx != IDX_CRC) begin
      crc <= crc_next;
    end
  end

  // Track the response wait
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b0;
      tries    <= '0;
    end else if (consume) begin
      if (is_issue) begin
        awaiting <= 1'b1;
        tries    <= '0;
      end else if (awaiting) begin
        tries <= tries_next;
        if (!hold.rx_byte[7] || tries_next >= TRY_LIMIT) begin
          awaiting <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sdspi_checker.sv */
// Port-level checks for the SD SPI command exchange, bound to the top level.
`default_nettype none

module sdspi_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire sdspi_pkg::rsp_t rsp
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Never send and report in the same item
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.tx_valid && rsp.r1_valid))
    else $error("result both sends and reports");

  // A report always closes its item
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.r1_valid |-> rsp.last)
    else $error("report not marked last");

  // A timeout reports a byte with bit 7 set; a real R1 has it clear
  a_r1_bit7: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.r1_valid |-> (rsp.r1[7] == rsp.no_response))
    else $error("R1 bit 7 disagrees with no_response");

  // The frame end byte carries the stop bit
  a_stop_bit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.tx_valid && rsp.last && rsp.tx_byte != 8'hFF |-> rsp.tx_byte[0])
    else $error("frame end byte lacks stop bit");

endmodule

bind sd_spi_command_exchange sdspi_checker u_sdspi_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
